// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A same-cycle implication that must hold outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itp_pkg.sv =====
package itp_pkg;

    // Symbol width and default operator stack depth.
    localparam int SYM_W = 8;
    localparam int STACK_DEPTH_DEF = 16;

    // Depth of the queue between the classifier and the stack engine.
    localparam int QUEUE_DEPTH = 2;

    // Characters with a role of their own.
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

    // Status codes carried on every result of a transaction.
    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW       = 2'd2;
    localparam logic [1:0] ST_UNMATCHED_OPEN = 2'd3;

    typedef enum logic [1:0] {
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER
    } sym_class_t;

    // One classified input character as it waits in the queue.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        sym_class_t       cls;
        logic [1:0]       prec;
        logic             strict;
    } queue_entry_t;

    // Stack condition flags reported by the stack engine.
    typedef struct packed {
        logic empty;
        logic opens_present;
    } stack_info_t;

    // Operator precedence; every other symbol ranks zero.
    function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_CARET) begin
            p = 2'd3;
        end
        return p;
    endfunction

    // ASCII letters and digits only.
    function automatic logic is_alnum(input logic [SYM_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// ===== rtl/itp_ram.sv =====
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/itp_front.sv =====
module itp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [itp_pkg::SYM_W-1:0]   s_in_symbol,
    input  logic                        s_in_last,
    input  logic                        power_right_assoc,
    output itp_pkg::queue_entry_t       q_head,
    output logic                        q_valid,
    input  logic                        q_pop
);
    import itp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t   slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]  fill_reg, fill_next;
    queue_entry_t   new_entry;
    logic           push, pop;

    // Classify the incoming character.
    always_comb begin
        new_entry.sym    = s_in_symbol;
        new_entry.last   = s_in_last;
        new_entry.prec   = prec_of(s_in_symbol);
        new_entry.strict = (s_in_symbol == CH_CARET) && power_right_assoc;
        if (is_alnum(s_in_symbol)) begin
            new_entry.cls = CLS_ALNUM;
        end else if (s_in_symbol == CH_LPAREN) begin
            new_entry.cls = CLS_OPEN;
        end else if (s_in_symbol == CH_RPAREN) begin
            new_entry.cls = CLS_CLOSE;
        end else begin
            new_entry.cls = CLS_OPER;
        end
    end

    assign s_ready = (fill_reg != FW'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_head  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Queue pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue slots hold payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// ===== rtl/itp_back.sv =====
module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  itp_pkg::queue_entry_t       q_head,
    input  logic                        q_valid,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [itp_pkg::SYM_W-1:0]   m_out_symbol,
    output logic                        m_out_valid,
    output logic                        m_run_end,
    output logic [1:0]                  m_status,
    output itp_pkg::stack_info_t        info
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POPW  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       ret_reg, ret_next;
    logic [SYM_W-1:0] cur_sym_reg, cur_sym_next;
    logic             cur_last_reg, cur_last_next;
    sym_class_t       cur_cls_reg, cur_cls_next;
    logic [1:0]       cur_prec_reg, cur_prec_next;
    logic             cur_strict_reg, cur_strict_next;
    logic [1:0]       status_reg, status_next;
    logic [SYM_W-1:0] top_reg, top_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    open_reg, open_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             pend_flag_reg, pend_flag_next;
    logic             m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] m_sym_reg, m_sym_next;
    logic             m_flag_reg, m_flag_next;
    logic             m_end_reg, m_end_next;
    logic [1:0]       m_status_reg, m_status_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [SYM_W-1:0] ram_rdata;
    logic [CW-1:0]    cnt_m1, cnt_m2;

    logic             out_free, can_emit, stack_full, after_last;
    logic             head_top_pop, cur_top_pop, head_open_after;
    logic [1:0]       head_item_status, head_status;
    logic [2:0]       after_state;
    logic             do_push, do_pop, emit_req, out_load;
    logic [SYM_W-1:0] emit_sym, out_sym;
    logic             emit_flag, out_flag, out_end;

    // Entries below the cached top of stack live in the RAM.
    itp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_m1      = count_reg - CW'(1);
    assign cnt_m2      = count_reg - CW'(2);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));
    assign out_free    = !m_valid_reg || m_ready;
    assign can_emit    = !pend_valid_reg || out_free;
    assign after_last  = cur_last_reg;
    assign after_state = after_last ? S_FLUSH : S_DONE;

    // Whether the stacked top yields to the operator at the queue head or in work.
    assign head_top_pop = (count_reg != '0) && (top_reg != CH_LPAREN) &&
                          (q_head.strict ? (prec_of(top_reg) > q_head.prec)
                                         : (prec_of(top_reg) >= q_head.prec));
    assign cur_top_pop  = (count_reg != '0) && (top_reg != CH_LPAREN) &&
                          (cur_strict_reg ? (prec_of(top_reg) > cur_prec_reg)
                                          : (prec_of(top_reg) >= cur_prec_reg));

    // The status of a transaction is settled from the stack before any pop.
    always_comb begin
        head_item_status = ST_OK;
        head_open_after  = (open_reg != '0);
        case (q_head.cls)
            CLS_CLOSE: begin
                if (open_reg == '0) begin
                    head_item_status = ST_UNMATCHED_CLOSE;
                end
                head_open_after = (open_reg > CW'(1));
            end
            CLS_OPEN: begin
                if (stack_full) begin
                    head_item_status = ST_OVERFLOW;
                end else begin
                    head_open_after = 1'b1;
                end
            end
            CLS_OPER: begin
                if (stack_full && !head_top_pop) begin
                    head_item_status = ST_OVERFLOW;
                end
            end
            default: begin
                head_item_status = ST_OK;
            end
        endcase
        if (head_item_status != ST_OK) begin
            head_status = head_item_status;
        end else if (q_head.last && head_open_after) begin
            head_status = ST_UNMATCHED_OPEN;
        end else begin
            head_status = ST_OK;
        end
    end

    // Sequencer for one transaction: execute, flush after a last character, then close the run.
    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cur_sym_next    = cur_sym_reg;
        cur_last_next   = cur_last_reg;
        cur_cls_next    = cur_cls_reg;
        cur_prec_next   = cur_prec_reg;
        cur_strict_next = cur_strict_reg;
        status_next     = status_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_flag_next  = pend_flag_reg;
        m_valid_next    = m_valid_reg;
        m_sym_next      = m_sym_reg;
        m_flag_next     = m_flag_reg;
        m_end_next      = m_end_reg;
        m_status_next   = m_status_reg;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        emit_req  = 1'b0;
        emit_sym  = '0;
        emit_flag = 1'b0;
        out_load  = 1'b0;
        out_sym   = '0;
        out_flag  = 1'b0;
        out_end   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    cur_sym_next    = q_head.sym;
                    cur_last_next   = q_head.last;
                    cur_cls_next    = q_head.cls;
                    cur_prec_next   = q_head.prec;
                    cur_strict_next = q_head.strict;
                    status_next     = head_status;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC: begin
                case (cur_cls_reg)
                    CLS_ALNUM: begin
                        if (can_emit) begin
                            emit_req   = 1'b1;
                            emit_sym   = cur_sym_reg;
                            emit_flag  = 1'b1;
                            state_next = after_state;
                        end
                    end
                    CLS_OPEN: begin
                        do_push    = !stack_full;
                        state_next = after_state;
                    end
                    CLS_CLOSE: begin
                        if (count_reg == '0) begin
                            state_next = after_state;
                        end else if (top_reg == CH_LPAREN) begin
                            do_pop     = 1'b1;
                            ret_next   = after_state;
                            state_next = S_POPW;
                        end else if (can_emit) begin
                            emit_req   = 1'b1;
                            emit_sym   = top_reg;
                            emit_flag  = 1'b1;
                            do_pop     = 1'b1;
                            ret_next   = S_EXEC;
                            state_next = S_POPW;
                        end
                    end
                    default: begin
                        if (!cur_top_pop) begin
                            do_push    = !stack_full;
                            state_next = after_state;
                        end else if (can_emit) begin
                            emit_req   = 1'b1;
                            emit_sym   = top_reg;
                            emit_flag  = 1'b1;
                            do_pop     = 1'b1;
                            ret_next   = S_EXEC;
                            state_next = S_POPW;
                        end
                    end
                endcase
            end
            S_POPW: begin
                top_next   = ram_rdata;
                state_next = ret_reg;
            end
            S_FLUSH: begin
                if (count_reg != '0) begin
                    if (top_reg == CH_LPAREN) begin
                        do_pop     = 1'b1;
                        ret_next   = S_FLUSH;
                        state_next = S_POPW;
                    end else if (can_emit) begin
                        emit_req   = 1'b1;
                        emit_sym   = top_reg;
                        emit_flag  = 1'b1;
                        do_pop     = 1'b1;
                        ret_next   = S_FLUSH;
                        state_next = S_POPW;
                    end
                end else if (can_emit) begin
                    // Bare end marker closes the expression.
                    emit_req   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_sym         = pend_sym_reg;
                        out_flag        = pend_flag_reg;
                        out_end         = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end else if (status_reg != ST_OK) begin
                    // An error with no output still shows up as a bare marker.
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_end    = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Push: the old top moves into the RAM.
        if (do_push) begin
            if (count_reg != '0) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m1[AW-1:0];
            end
            top_next   = cur_sym_reg;
            count_next = count_reg + CW'(1);
            if (cur_cls_reg == CLS_OPEN) begin
                open_next = open_reg + CW'(1);
            end
        end

        // Pop: fetch the entry below the top for the wait state.
        if (do_pop) begin
            ram_raddr  = cnt_m2[AW-1:0];
            count_next = cnt_m1;
            if (top_reg == CH_LPAREN) begin
                open_next = open_reg - CW'(1);
            end
        end

        // A new result displaces the held one, which then is not the run's last.
        if (emit_req) begin
            if (pend_valid_reg) begin
                out_load = 1'b1;
                out_sym  = pend_sym_reg;
                out_flag = pend_flag_reg;
                out_end  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = emit_sym;
            pend_flag_next  = emit_flag;
        end

        // Output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_sym_next    = out_sym;
            m_flag_next   = out_flag;
            m_end_next    = out_end;
            m_status_next = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= '0;
            open_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_sym_reg    <= cur_sym_next;
        cur_last_reg   <= cur_last_next;
        cur_cls_reg    <= cur_cls_next;
        cur_prec_reg   <= cur_prec_next;
        cur_strict_reg <= cur_strict_next;
        status_reg     <= status_next;
        top_reg        <= top_next;
        pend_sym_reg   <= pend_sym_next;
        pend_flag_reg  <= pend_flag_next;
        m_sym_reg      <= m_sym_next;
        m_flag_reg     <= m_flag_next;
        m_end_reg      <= m_end_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_sym_reg;
    assign m_out_valid  = m_flag_reg;
    assign m_run_end    = m_end_reg;
    assign m_status     = m_status_reg;

    assign info.empty         = (count_reg == '0);
    assign info.opens_present = (open_reg != '0);

endmodule

// ===== rtl/infix_to_postfix_converter_core.sv =====
// Flow: an accepted character waits in the input queue until the stack engine takes it; a letter
// passes through the working registers and a pending hold register to the output register, and
// each result is held back one step so that its run-end flag is known when it leaves.
// The stack engine works on one character at a time, with a wait state for each stack pop (the
// stack RAM read) and an end marker after a last character; the input queue absorbs bursts.
// Reset (aresetn low, synchronous) empties the stack and queue and sets caret right assoc.
`include "assert_macros.svh"

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [itp_pkg::SYM_W-1:0]   s_in_symbol,
    input  logic                        s_in_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [itp_pkg::SYM_W-1:0]   m_out_symbol,
    output logic                        m_out_valid,
    output logic                        m_run_end,
    output logic [1:0]                  m_status,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata
);
    import itp_pkg::*;

    logic         power_right_assoc_reg;
    queue_entry_t q_head;
    logic         q_valid, q_pop;
    stack_info_t  info;

    // Caret associativity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_right_assoc_reg <= 1'b1;
        end else if (cfg_we) begin
            power_right_assoc_reg <= cfg_wdata;
        end
    end

    itp_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_symbol       (s_in_symbol),
        .s_in_last         (s_in_last),
        .power_right_assoc (power_right_assoc_reg),
        .q_head            (q_head),
        .q_valid           (q_valid),
        .q_pop             (q_pop)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_head       (q_head),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_symbol (m_out_symbol),
        .m_out_valid  (m_out_valid),
        .m_run_end    (m_run_end),
        .m_status     (m_status),
        .info         (info)
    );

    // A bare marker is always the final result of its transaction.
    `ASSERT_IMPLY(a_marker_ends_run, aclk, aresetn, m_valid && !m_out_valid, m_run_end,
                  "bare marker without run end")
    // Open parenthesis bookkeeping must agree with the stack fill.
    `ASSERT_IMPLY(a_empty_no_opens, aclk, aresetn, info.empty, !info.opens_present,
                  "open count nonzero on empty stack")

endmodule

// ===== verif/tb_infix_to_postfix_converter_core.sv =====
module tb_infix_to_postfix_converter_core;
    import itp_pkg::*;

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 240;
    localparam int TAIL_ITEMS    = 40;
    localparam int PHASE_ITEMS   = 45;

    // One postfix output transaction as the converter should produce it.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             sym_valid;
        logic             run_end;
        logic [1:0]       status;
    } postfix_item_t;

    // Shapes of generated expressions.
    typedef enum int {
        EXPR_PLAIN,
        EXPR_DEEP,
        EXPR_BROKEN,
        EXPR_NOISE
    } expr_kind_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [SYM_W-1:0] s_in_symbol = '0;
    logic             s_in_last   = 1'b0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [SYM_W-1:0] m_out_symbol;
    logic             m_out_valid;
    logic             m_run_end;
    logic [1:0]       m_status;
    logic             cfg_we      = 1'b0;
    logic             cfg_wdata   = 1'b0;

    // Shadow of the operator stack and the caret mode register.
    logic [SYM_W-1:0] shadow_stack [DEPTH];
    int               shadow_depth = 0;
    logic             caret_right  = 1'b1;

    postfix_item_t    postfix_q[$];
    logic [SYM_W-1:0] expr_chars[$];
    logic [SYM_W-1:0] operator_set [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    string            alnum_set =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    int idle_pct       = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;
    int mismatch_count = 0;
    int chars_sent     = 0;
    int expr_count     = 0;
    int results_seen   = 0;

    infix_to_postfix_converter_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_symbol  (s_in_symbol),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_symbol (m_out_symbol),
        .m_out_valid  (m_out_valid),
        .m_run_end    (m_run_end),
        .m_status     (m_status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // Free-running clock.
    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // Operator ranking used by the shadow stack.
    function automatic logic [1:0] rank_of(input logic [SYM_W-1:0] c);
        if (c == CH_PLUS || c == CH_MINUS) begin
            return 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            return 2'd2;
        end else if (c == CH_CARET) begin
            return 2'd3;
        end
        return 2'd0;
    endfunction

    // Plain ASCII letters and digits go straight to the output.
    function automatic logic passes_through(input logic [SYM_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic postfix_item_t make_out(input logic [SYM_W-1:0] c, input logic v);
        postfix_item_t r;
        r.sym       = c;
        r.sym_valid = v;
        r.run_end   = 1'b0;
        r.status    = ST_OK;
        return r;
    endfunction

    // A push onto a full stack is lost and reports overflow unless an error is already set.
    task automatic shadow_push(input logic [SYM_W-1:0] c, inout logic [1:0] st);
        if (shadow_depth < DEPTH) begin
            shadow_stack[shadow_depth] = c;
            shadow_depth++;
        end else if (st == ST_OK) begin
            st = ST_OVERFLOW;
        end
    endtask

    // Work out the postfix transactions caused by one accepted character.
    task automatic predict_postfix(input logic [SYM_W-1:0] c, input logic last);
        postfix_item_t    outs[$];
        logic [1:0]       st;
        logic [1:0]       p;
        logic [SYM_W-1:0] t;
        logic             strict;
        logic             done;
        st = ST_OK;
        if (passes_through(c)) begin
            outs.push_back(make_out(c, 1'b1));
        end else if (c == CH_LPAREN) begin
            shadow_push(c, st);
        end else if (c == CH_RPAREN) begin
            while (shadow_depth > 0 && shadow_stack[shadow_depth - 1] != CH_LPAREN) begin
                shadow_depth--;
                outs.push_back(make_out(shadow_stack[shadow_depth], 1'b1));
            end
            if (shadow_depth > 0) begin
                shadow_depth--;
            end else begin
                st = ST_UNMATCHED_CLOSE;
            end
        end else begin
            // Pop while top binds at least as tightly (right caret: tighter); stop at '('.
            p      = rank_of(c);
            strict = (c == CH_CARET) && caret_right;
            done   = 1'b0;
            while (shadow_depth > 0 && !done) begin
                t = shadow_stack[shadow_depth - 1];
                if (t == CH_LPAREN) begin
                    done = 1'b1;
                end else if (strict ? (rank_of(t) > p) : (rank_of(t) >= p)) begin
                    shadow_depth--;
                    outs.push_back(make_out(t, 1'b1));
                end else begin
                    done = 1'b1;
                end
            end
            shadow_push(c, st);
        end

        // Flush at the end of the expression; leftover open brackets are dropped.
        if (last) begin
            while (shadow_depth > 0) begin
                shadow_depth--;
                t = shadow_stack[shadow_depth];
                if (t == CH_LPAREN) begin
                    if (st == ST_OK) begin
                        st = ST_UNMATCHED_OPEN;
                    end
                end else begin
                    outs.push_back(make_out(t, 1'b1));
                end
            end
            outs.push_back(make_out('0, 1'b0));
        end else if (outs.size() == 0 && st != ST_OK) begin
            outs.push_back(make_out('0, 1'b0));
        end

        foreach (outs[k]) begin
            outs[k].run_end = (k == outs.size() - 1);
            outs[k].status  = st;
            postfix_q.push_back(outs[k]);
        end
    endtask

    function automatic void check_field(input string name, input logic [SYM_W-1:0] want,
                                        input logic [SYM_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare every output transaction with the oldest pending prediction.
    always @(posedge aclk) begin
        postfix_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (postfix_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none, actual %0h %b %b %0d",
                         $time, m_out_symbol, m_out_valid, m_run_end, m_status);
            end else begin
                want = postfix_q.pop_front();
                check_field("out_symbol", want.sym, m_out_symbol);
                check_field("out_valid", want.sym_valid, m_out_valid);
                check_field("run_end", want.run_end, m_run_end);
                check_field("status", want.status, m_status);
            end
        end
    end

    // Receiver backpressure in random bursts while idling is enabled.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results pending",
                         $time, idle_cycles, postfix_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one character and wait until it is taken.
    task automatic send_char(input logic [SYM_W-1:0] c, input logic last);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_symbol <= c;
        s_in_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_postfix(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input logic last_at_end);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], last_at_end && (i == txt.len() - 1));
        end
    endtask

    task automatic send_expression();
        foreach (expr_chars[i]) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        end
        expr_count++;
    endtask

    // Drop valid, let all predicted output drain, then allow for work that emits nothing.
    task automatic wait_converter_idle();
        s_valid <= 1'b0;
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_caret_mode(input logic right);
        wait_converter_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= right;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        caret_right  = right;
    endtask

    function automatic logic [SYM_W-1:0] pick_byte();
        return SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [SYM_W-1:0] pick_operand();
        return alnum_set[$urandom_range(0, alnum_set.len() - 1)];
    endfunction

    // Mostly arithmetic operators, now and then an arbitrary byte used as an operator.
    function automatic logic [SYM_W-1:0] pick_operator();
        if ($urandom_range(0, 9) == 0) begin
            return pick_byte();
        end
        return operator_set[$urandom_range(0, 4)];
    endfunction

    // Build one expression into expr_chars; the final character will carry last.
    task automatic build_expression(input expr_kind_t kind);
        int depth;
        int operands;
        int open_pct;
        int max_depth;
        int len;
        bit want_operand;
        expr_chars.delete();
        if (kind == EXPR_NOISE) begin
            len = $urandom_range(1, 8);
            repeat (len) expr_chars.push_back(pick_byte());
            return;
        end
        open_pct     = (kind == EXPR_DEEP) ? 80 : 25;
        max_depth    = (kind == EXPR_DEEP) ? DEPTH + 2 : 4;
        operands     = (kind == EXPR_DEEP) ? $urandom_range(2, 5) : $urandom_range(1, 6);
        depth        = 0;
        want_operand = 1'b1;
        while (operands > 0) begin
            if (want_operand) begin
                if (depth < max_depth && $urandom_range(0, 99) < open_pct) begin
                    expr_chars.push_back(CH_LPAREN);
                    depth++;
                end else begin
                    expr_chars.push_back(pick_operand());
                    operands--;
                    want_operand = 1'b0;
                end
            end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
                expr_chars.push_back(CH_RPAREN);
                depth--;
            end else begin
                expr_chars.push_back(pick_operator());
                want_operand = 1'b1;
            end
        end
        while (depth > 0) begin
            expr_chars.push_back(CH_RPAREN);
            depth--;
        end

        // Damage a well-formed expression with stray bytes and brackets.
        if (kind == EXPR_BROKEN) begin
            foreach (expr_chars[i]) begin
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            expr_chars[i] = CH_LPAREN;
                        end
                        1: begin
                            expr_chars[i] = CH_RPAREN;
                        end
                        default: begin
                            expr_chars[i] = pick_byte();
                        end
                    endcase
                end
            end
        end
    endtask

    function automatic expr_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll <= 5) begin
            return EXPR_PLAIN;
        end else if (roll == 6) begin
            return EXPR_DEEP;
        end else if (roll <= 8) begin
            return EXPR_BROKEN;
        end
        return EXPR_NOISE;
    endfunction

    // Brackets, caret chaining, lone closes, extreme codes and an unmatched open.
    task automatic test_directed_paths();
        idle_pct = 20;
        send_text("(a+Z)^9^z", 1'b1);
        send_char(CH_RPAREN, 1'b0);
        send_text("x-", 1'b0);
        send_char(CH_RPAREN, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_LPAREN, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_SLASH, 1'b1);
    endtask

    // Fill the stack with brackets, then push one more at the end of the expression.
    task automatic test_stack_overflow();
        idle_pct = 10;
        repeat (DEPTH) send_char(CH_LPAREN, 1'b0);
        send_char(CH_STAR, 1'b1);
    endtask

    // Random expressions in phases with changing caret mode and idling.
    task automatic test_random_expressions();
        int phase;
        int start_count;
        int phase_start;
        phase       = 0;
        start_count = chars_sent;
        while (chars_sent - start_count < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    write_caret_mode(1'b0);
                end
                1: begin
                    write_caret_mode(1'b1);
                end
                default: begin
                    write_caret_mode(1'($urandom_range(0, 1)));
                end
            endcase
            case (phase % 3)
                0: begin
                    idle_pct = 40;
                end
                1: begin
                    idle_pct = 0;
                end
                default: begin
                    idle_pct = 15;
                end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_ITEMS &&
                   chars_sent - start_count < RANDOM_ITEMS) begin
                build_expression(pick_kind());
                send_expression();
            end
            phase++;
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_calm_tail();
        int start_count;
        idle_pct    = 0;
        start_count = chars_sent;
        while (chars_sent - start_count < TAIL_ITEMS) begin
            build_expression(pick_kind());
            send_expression();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_paths();
        test_stack_overflow();
        test_random_expressions();
        test_calm_tail();
        wait_converter_idle();

        $display("Sent %0d characters in %0d expressions and checked %0d postfix transactions.",
                 chars_sent, expr_count, results_seen);
        $display("Both caret modes, stack overflow, stray brackets and arbitrary bytes were driven.");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_ram.sv
rtl/itp_front.sv
rtl/itp_back.sv
rtl/infix_to_postfix_converter_core.sv
verif/tb_infix_to_postfix_converter_core.sv
